### sv/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for the quaternion to Euler converter
// Fixed-point widths, CORDIC arctangent table and output limits.
// ----------------------------------------------------------------------------
package qte_pkg;

    // field widths
    localparam int COMP_W   = 16;     // quaternion component, Q1.14
    localparam int OUT_W    = 16;     // roll / yaw word
    localparam int PITCH_W  = 15;     // pitch word

    // internal widths
    localparam int ARG_W    = 36;     // atan2 arguments
    localparam int XY_W     = 45;     // CORDIC vector coordinates
    localparam int NORM_W   = 41;     // normalized magnitude, top bit at NORM_W-1
    localparam int ANG_W    = 31;     // angle accumulator, 2^-20 degree
    localparam int PROD_W   = 32;     // 16x16 product
    localparam int DIV_D_W  = 33;     // squared norm
    localparam int DIV_R_W  = 34;     // divider partial remainder
    localparam int QUO_W    = 31;     // Q.30 sine magnitude, also root width
    localparam int RAD_W    = 61;     // radicand of the cosine root
    localparam int ROOT_W   = 62;     // root accumulator

    // CORDIC
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TAB_LEN           = 24;

    // angles in 2^-20 degree
    localparam int ANG_90   = 94371840;
    localparam int ANG_180  = 188743680;

    // output rounding to 1/128 degree and limits
    localparam int RND_SHIFT = 13;
    localparam int RND_HALF  = 4096;
    localparam int ROLL_LIM  = 23040;
    localparam int PITCH_LIM = 11520;

    typedef logic signed [ANG_W-1:0]  ang_t;
    typedef logic signed [XY_W-1:0]   xy_t;
    typedef logic signed [ARG_W-1:0]  arg_t;
    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // fixed-angle override for degenerate vectors
    typedef struct packed {
        logic fix;
        ang_t fang;
    } fix_t;

    // atan(2^-i) in 2^-20 degree
    function automatic ang_t atan_entry(input int idx);
        ang_t v;
        case (idx)
            0:  v = ANG_W'(47185920);
            1:  v = ANG_W'(27855475);
            2:  v = ANG_W'(14718068);
            3:  v = ANG_W'(7471121);
            4:  v = ANG_W'(3750058);
            5:  v = ANG_W'(1876857);
            6:  v = ANG_W'(938658);
            7:  v = ANG_W'(469357);
            8:  v = ANG_W'(234682);
            9:  v = ANG_W'(117342);
            10: v = ANG_W'(58671);
            11: v = ANG_W'(29335);
            12: v = ANG_W'(14668);
            13: v = ANG_W'(7334);
            14: v = ANG_W'(3667);
            15: v = ANG_W'(1833);
            16: v = ANG_W'(917);
            17: v = ANG_W'(458);
            18: v = ANG_W'(229);
            19: v = ANG_W'(115);
            20: v = ANG_W'(57);
            21: v = ANG_W'(29);
            22: v = ANG_W'(14);
            23: v = ANG_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### sv/qte_quat_if.sv
// ----------------------------------------------------------------------------
// qte_quat_if: quaternion input channel
// Valid/ready handshake carrying one quaternion word.
// ----------------------------------------------------------------------------
interface qte_quat_if;
    logic                 valid;
    logic                 ready;
    qte_pkg::comp_t       quat_w;
    qte_pkg::comp_t       quat_x;
    qte_pkg::comp_t       quat_y;
    qte_pkg::comp_t       quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

### sv/qte_euler_if.sv
// ----------------------------------------------------------------------------
// qte_euler_if: Euler angle output channel
// Valid/ready handshake carrying roll, pitch, yaw and the invalid flag.
// ----------------------------------------------------------------------------
interface qte_euler_if;
    logic                                valid;
    logic                                ready;
    logic signed [qte_pkg::OUT_W-1:0]    roll_deg;
    logic signed [qte_pkg::PITCH_W-1:0]  pitch_deg;
    logic signed [qte_pkg::OUT_W-1:0]    yaw_deg;
    logic                                invalid;

    modport source (output valid, output roll_deg, output pitch_deg,
                    output yaw_deg, output invalid, input ready);
    modport sink   (input valid, input roll_deg, input pitch_deg,
                    input yaw_deg, input invalid, output ready);
endinterface

### sv/qte_div_cell.sv
// ----------------------------------------------------------------------------
// qte_div_cell: one restoring division cell
// Produces one quotient bit per cell and passes the doubled remainder on.
// ----------------------------------------------------------------------------
module qte_div_cell (
    input  logic                          clk,
    input  logic                          en,
    input  logic [qte_pkg::DIV_R_W-1:0]   r_in,
    input  logic [qte_pkg::DIV_D_W-1:0]   d_in,
    input  logic [qte_pkg::QUO_W-1:0]     q_in,
    output logic [qte_pkg::DIV_R_W-1:0]   r_out,
    output logic [qte_pkg::DIV_D_W-1:0]   d_out,
    output logic [qte_pkg::QUO_W-1:0]     q_out
);

    logic [qte_pkg::DIV_R_W-1:0] r_reg, r_next;
    logic [qte_pkg::DIV_D_W-1:0] d_reg;
    logic [qte_pkg::QUO_W-1:0]   q_reg, q_next;
    logic [qte_pkg::DIV_R_W-1:0] d_ext;
    logic [qte_pkg::DIV_R_W-1:0] rs;
    logic                        ge;

    // compare, subtract, then double for the next cell
    always_comb
    begin
        d_ext  = {1'b0, d_in};
        ge     = (r_in >= d_ext);
        rs     = ge ? (r_in - d_ext) : r_in;
        r_next = {rs[qte_pkg::DIV_R_W-2:0], 1'b0};
        q_next = {q_in[qte_pkg::QUO_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
            d_reg <= d_in;
            q_reg <= q_next;
        end
    end

    assign r_out = r_reg;
    assign d_out = d_reg;
    assign q_out = q_reg;

endmodule

### sv/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell: one digit cell of the integer square root
// Tries the root bit of weight 2^STEP and updates remainder and root.
// ----------------------------------------------------------------------------
module qte_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [qte_pkg::RAD_W-1:0]    n_in,
    input  logic [qte_pkg::ROOT_W-1:0]   res_in,
    output logic [qte_pkg::RAD_W-1:0]    n_out,
    output logic [qte_pkg::ROOT_W-1:0]   res_out
);

    localparam logic [qte_pkg::ROOT_W-1:0] BIT = qte_pkg::ROOT_W'(1) << (2 * STEP);

    logic [qte_pkg::RAD_W-1:0]  n_reg, n_next;
    logic [qte_pkg::ROOT_W-1:0] res_reg, res_next;
    logic [qte_pkg::ROOT_W-1:0] trial;
    logic                       ge;

    // trial subtract of res + bit
    always_comb
    begin
        trial    = res_in + BIT;
        ge       = ({1'b0, n_in} >= trial);
        n_next   = ge ? (n_in - trial[qte_pkg::RAD_W-1:0]) : n_in;
        res_next = ge ? ((res_in >> 1) + BIT) : (res_in >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg   <= n_next;
            res_reg <= res_next;
        end
    end

    assign n_out   = n_reg;
    assign res_out = res_reg;

endmodule

### sv/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates toward y = 0 by atan(2^-IDX) and tracks the angle.
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic           clk,
    input  logic           en,
    input  qte_pkg::xy_t   x_in,
    input  qte_pkg::xy_t   y_in,
    input  qte_pkg::ang_t  ang_in,
    output qte_pkg::xy_t   x_out,
    output qte_pkg::xy_t   y_out,
    output qte_pkg::ang_t  ang_out
);

    localparam qte_pkg::ang_t TAB = qte_pkg::atan_entry(IDX);

    qte_pkg::xy_t  x_reg, x_next, y_reg, y_next, dx, dy;
    qte_pkg::ang_t ang_reg, ang_next;

    // floor shifts and direction from the sign of y
    always_comb
    begin
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
        if (y_in > 0)
        begin
            x_next   = x_in + dx;
            y_next   = y_in - dy;
            ang_next = ang_in + TAB;
        end
        else
        begin
            x_next   = x_in - dx;
            y_next   = y_in + dy;
            ang_next = ang_in - TAB;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            ang_reg <= ang_next;
        end
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign ang_out = ang_reg;

endmodule

### sv/qte_atan2.sv
// ----------------------------------------------------------------------------
// qte_atan2: pipelined atan2 in degrees
// Half-plane fold, two normalize stages, a row of CORDIC cells and a
// rounding/saturation stage.
// ----------------------------------------------------------------------------
module qte_atan2 #(
    parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF,
    parameter int LIM    = qte_pkg::ROLL_LIM
) (
    input  logic                               clk,
    input  logic                               en,
    input  qte_pkg::arg_t                      y_in,
    input  qte_pkg::arg_t                      x_in,
    output logic signed [qte_pkg::OUT_W-1:0]   ang_out
);

    localparam int XY_W   = qte_pkg::XY_W;
    localparam int NORM_W = qte_pkg::NORM_W;
    localparam int ANG_W  = qte_pkg::ANG_W;

    // fold stage
    qte_pkg::xy_t          x1_reg, y1_reg, x1_next, y1_next;
    logic [NORM_W-1:0]     m1_reg, m1_next;
    qte_pkg::ang_t         a1_reg, a1_next;
    qte_pkg::fix_t         f1_next;
    qte_pkg::xy_t          ay;

    // normalize stages
    qte_pkg::xy_t          x2_reg, y2_reg, x2_next, y2_next;
    logic [NORM_W-1:0]     m2_reg, m2_next;
    qte_pkg::ang_t         a2_reg;
    qte_pkg::xy_t          x3_reg, y3_reg, x3_next, y3_next;
    qte_pkg::ang_t         a3_reg;
    logic [NORM_W-1:0]     m3_next;

    // override carried beside the cells
    qte_pkg::fix_t         fix_reg [STAGES+3];

    // cell chain
    qte_pkg::xy_t          cx [STAGES+1];
    qte_pkg::xy_t          cy [STAGES+1];
    qte_pkg::ang_t         ca [STAGES+1];

    // rounding
    qte_pkg::ang_t         a_sel;
    logic [ANG_W-1:0]      mag, rsum, r, rs;
    logic                  aneg;
    logic signed [qte_pkg::OUT_W-1:0] out_reg, out_next;

    // fold to the right half plane, flag degenerate vectors
    always_comb
    begin
        x1_next = XY_W'(x_in);
        y1_next = XY_W'(y_in);
        a1_next = '0;
        if (x_in < 0)
        begin
            x1_next = -XY_W'(x_in);
            y1_next = -XY_W'(y_in);
            a1_next = (y_in >= 0) ? ANG_W'(qte_pkg::ANG_180) : -ANG_W'(qte_pkg::ANG_180);
        end
        ay = (y1_next < 0) ? -y1_next : y1_next;
        m1_next = (x1_next > ay) ? x1_next[NORM_W-1:0] : ay[NORM_W-1:0];

        f1_next.fix  = 1'b0;
        f1_next.fang = '0;
        if (y_in == 0)
        begin
            f1_next.fix  = 1'b1;
            f1_next.fang = (x_in < 0) ? ANG_W'(qte_pkg::ANG_180) : '0;
        end
        else if (x_in == 0)
        begin
            f1_next.fix  = 1'b1;
            f1_next.fang = (y_in > 0) ? ANG_W'(qte_pkg::ANG_90) : -ANG_W'(qte_pkg::ANG_90);
        end
    end

    // coarse normalize: shifts of 32, 16, 8
    always_comb
    begin
        x2_next = x1_reg;
        y2_next = y1_reg;
        m2_next = m1_reg;
        for (int j = 0; j < 3; j++)
        begin
            if (m2_next < (NORM_W'(1) << (NORM_W - (32 >> j))))
            begin
                m2_next = m2_next << (32 >> j);
                x2_next = x2_next <<< (32 >> j);
                y2_next = y2_next <<< (32 >> j);
            end
        end
    end

    // fine normalize: shifts of 4, 2, 1
    always_comb
    begin
        x3_next = x2_reg;
        y3_next = y2_reg;
        m3_next = m2_reg;
        for (int j = 0; j < 3; j++)
        begin
            if (m3_next < (NORM_W'(1) << (NORM_W - (4 >> j))))
            begin
                m3_next = m3_next << (4 >> j);
                x3_next = x3_next <<< (4 >> j);
                y3_next = y3_next <<< (4 >> j);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= x1_next;
            y1_reg <= y1_next;
            m1_reg <= m1_next;
            a1_reg <= a1_next;
            x2_reg <= x2_next;
            y2_reg <= y2_next;
            m2_reg <= m2_next;
            a2_reg <= a1_reg;
            x3_reg <= x3_next;
            y3_reg <= y3_next;
            a3_reg <= a2_reg;
            fix_reg[0] <= f1_next;
            for (int i = 1; i < STAGES + 3; i++)
            begin
                fix_reg[i] <= fix_reg[i-1];
            end
        end
    end

    // micro-rotation cells
    assign cx[0] = x3_reg;
    assign cy[0] = y3_reg;
    assign ca[0] = a3_reg;

    for (genvar g = 0; g < STAGES; g++)
    begin : g_cell
        qte_cordic_cell #(
            .IDX (g)
        ) u_cell (
            .clk     (clk),
            .en      (en),
            .x_in    (cx[g]),
            .y_in    (cy[g]),
            .ang_in  (ca[g]),
            .x_out   (cx[g+1]),
            .y_out   (cy[g+1]),
            .ang_out (ca[g+1])
        );
    end

    // round magnitude half up to 1/128 degree and saturate
    always_comb
    begin
        a_sel    = fix_reg[STAGES+2].fix ? fix_reg[STAGES+2].fang : ca[STAGES];
        aneg     = a_sel[ANG_W-1];
        mag      = aneg ? (~a_sel + 1'b1) : a_sel;
        rsum     = mag + ANG_W'(qte_pkg::RND_HALF);
        r        = rsum >> qte_pkg::RND_SHIFT;
        if (r > ANG_W'(LIM))
        begin
            r = ANG_W'(LIM);
        end
        rs       = aneg ? (~r + 1'b1) : r;
        out_next = rs[qte_pkg::OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign ang_out = out_reg;

endmodule

### sv/quaternion_to_euler.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler: Z-Y-X Euler angles from a fixed-point quaternion
// CORDIC stages are capped at 24. Throughput: one word per cycle, set by
// the fully pipelined divider, square-root and CORDIC cell rows; the
// whole pipe holds on stall.
// Reset clears only the stage valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module quaternion_to_euler #(
    parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    qte_quat_if.sink        quat,
    qte_euler_if.source     euler
);

    localparam int NSTG    = (CORDIC_STAGES > qte_pkg::TAB_LEN) ? qte_pkg::TAB_LEN
                                                                 : CORDIC_STAGES;
    localparam int ATL     = NSTG + 4;
    localparam int DIV_N   = qte_pkg::QUO_W;
    localparam int SQRT_N  = qte_pkg::QUO_W;
    localparam int RY_DLY  = DIV_N + 1 + SQRT_N;
    localparam int LAT     = 2 + RY_DLY + ATL;
    localparam int INV_DLY = LAT - 2;
    localparam int ARG_W   = qte_pkg::ARG_W;
    localparam int QUO_W   = qte_pkg::QUO_W;
    localparam int RAD_W   = qte_pkg::RAD_W;
    localparam logic [QUO_W-1:0] Q30_ONE = QUO_W'(1) << (QUO_W - 1);
    localparam logic [RAD_W-1:0] Q60_ONE = RAD_W'(1) << (2 * (QUO_W - 1));

    logic                   en;
    logic [LAT-1:0]         vld_reg, vld_next;

    // stage 1: products
    qte_pkg::prod_t pww_reg, pxx_reg, pyy_reg, pzz_reg;
    qte_pkg::prod_t pwx_reg, pyz_reg, pwz_reg, pxy_reg, pwy_reg, pzx_reg;

    // stage 2: sums
    qte_pkg::arg_t  n2_s, t_s;
    qte_pkg::arg_t  ry_reg, rx_reg, yy_reg, yx_reg;
    qte_pkg::arg_t  ry_next, rx_next, yy_next, yx_next;
    logic [qte_pkg::DIV_D_W-1:0] n2_reg;
    logic [qte_pkg::DIV_D_W-1:0] tabs_reg, tabs_next;
    logic           tneg_reg, inv_reg;

    // divider row
    logic [qte_pkg::DIV_R_W-1:0] dr [DIV_N+1];
    logic [qte_pkg::DIV_D_W-1:0] dd [DIV_N+1];
    logic [QUO_W-1:0]            dq [DIV_N+1];
    logic                        sgn_dly_reg [DIV_N];

    // square stage
    logic [QUO_W-1:0]            qc;
    logic [2*QUO_W-1:0]          sq;
    logic [RAD_W-1:0]            rad_reg;
    qte_pkg::arg_t               s_reg, s_next;

    // root row
    logic [RAD_W-1:0]            rn [SQRT_N+1];
    logic [qte_pkg::ROOT_W-1:0]  rr [SQRT_N+1];
    qte_pkg::arg_t               s_dly_reg [SQRT_N];
    qte_pkg::arg_t               c_arg;

    // angles and alignment
    logic signed [qte_pkg::OUT_W-1:0] roll_a, yaw_a, pitch_a;
    logic signed [qte_pkg::OUT_W-1:0] roll_dly_reg [RY_DLY];
    logic signed [qte_pkg::OUT_W-1:0] yaw_dly_reg [RY_DLY];
    logic                              inv_dly_reg [INV_DLY];
    logic                              inv_out;

    // pipeline advances unless the output word is stalled
    assign en         = !vld_reg[LAT-1] || euler.ready;
    assign quat.ready = en;
    assign vld_next   = {vld_reg[LAT-2:0], quat.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    // sums of products, all terms exact
    always_comb
    begin
        n2_s      = ARG_W'(pww_reg) + ARG_W'(pxx_reg) + ARG_W'(pyy_reg) + ARG_W'(pzz_reg);
        ry_next   = (ARG_W'(pwx_reg) + ARG_W'(pyz_reg)) <<< 1;
        rx_next   = n2_s - ((ARG_W'(pxx_reg) + ARG_W'(pyy_reg)) <<< 1);
        yy_next   = (ARG_W'(pwz_reg) + ARG_W'(pxy_reg)) <<< 1;
        yx_next   = n2_s - ((ARG_W'(pyy_reg) + ARG_W'(pzz_reg)) <<< 1);
        t_s       = (ARG_W'(pwy_reg) - ARG_W'(pzx_reg)) <<< 1;
        tabs_next = (t_s < 0) ? qte_pkg::DIV_D_W'(-t_s) : qte_pkg::DIV_D_W'(t_s);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pww_reg  <= quat.quat_w * quat.quat_w;
            pxx_reg  <= quat.quat_x * quat.quat_x;
            pyy_reg  <= quat.quat_y * quat.quat_y;
            pzz_reg  <= quat.quat_z * quat.quat_z;
            pwx_reg  <= quat.quat_w * quat.quat_x;
            pyz_reg  <= quat.quat_y * quat.quat_z;
            pwz_reg  <= quat.quat_w * quat.quat_z;
            pxy_reg  <= quat.quat_x * quat.quat_y;
            pwy_reg  <= quat.quat_w * quat.quat_y;
            pzx_reg  <= quat.quat_z * quat.quat_x;

            n2_reg   <= n2_s[qte_pkg::DIV_D_W-1:0];
            ry_reg   <= ry_next;
            rx_reg   <= rx_next;
            yy_reg   <= yy_next;
            yx_reg   <= yx_next;
            tabs_reg <= tabs_next;
            tneg_reg <= (t_s < 0);
            inv_reg  <= (n2_s == 0);
        end
    end

    // roll and yaw
    qte_atan2 #(
        .STAGES (NSTG),
        .LIM    (qte_pkg::ROLL_LIM)
    ) u_roll (
        .clk     (clk),
        .en      (en),
        .y_in    (ry_reg),
        .x_in    (rx_reg),
        .ang_out (roll_a)
    );

    qte_atan2 #(
        .STAGES (NSTG),
        .LIM    (qte_pkg::ROLL_LIM)
    ) u_yaw (
        .clk     (clk),
        .en      (en),
        .y_in    (yy_reg),
        .x_in    (yx_reg),
        .ang_out (yaw_a)
    );

    // pitch sine magnitude: |t| * 2^30 / n2
    assign dr[0] = {1'b0, tabs_reg};
    assign dd[0] = n2_reg;
    assign dq[0] = '0;

    for (genvar g = 0; g < DIV_N; g++)
    begin : g_div
        qte_div_cell u_div (
            .clk   (clk),
            .en    (en),
            .r_in  (dr[g]),
            .d_in  (dd[g]),
            .q_in  (dq[g]),
            .r_out (dr[g+1]),
            .d_out (dd[g+1]),
            .q_out (dq[g+1])
        );
    end

    // clamp, square and signed sine
    always_comb
    begin
        qc     = (dq[DIV_N] > Q30_ONE) ? Q30_ONE : dq[DIV_N];
        sq     = qc * qc;
        s_next = sgn_dly_reg[DIV_N-1] ? -ARG_W'({1'b0, qc}) : ARG_W'({1'b0, qc});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= Q60_ONE - sq[RAD_W-1:0];
            s_reg   <= s_next;
        end
    end

    // cosine: integer root of 2^60 - s^2
    assign rn[0] = rad_reg;
    assign rr[0] = '0;

    for (genvar g = 0; g < SQRT_N; g++)
    begin : g_sqrt
        qte_sqrt_cell #(
            .STEP (SQRT_N - 1 - g)
        ) u_sqrt (
            .clk     (clk),
            .en      (en),
            .n_in    (rn[g]),
            .res_in  (rr[g]),
            .n_out   (rn[g+1]),
            .res_out (rr[g+1])
        );
    end

    assign c_arg = ARG_W'({1'b0, rr[SQRT_N][QUO_W-1:0]});

    qte_atan2 #(
        .STAGES (NSTG),
        .LIM    (qte_pkg::PITCH_LIM)
    ) u_pitch (
        .clk     (clk),
        .en      (en),
        .y_in    (s_dly_reg[SQRT_N-1]),
        .x_in    (c_arg),
        .ang_out (pitch_a)
    );

    // alignment delay lines
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sgn_dly_reg[0] <= tneg_reg;
            for (int i = 1; i < DIV_N; i++)
            begin
                sgn_dly_reg[i] <= sgn_dly_reg[i-1];
            end
            s_dly_reg[0] <= s_reg;
            for (int i = 1; i < SQRT_N; i++)
            begin
                s_dly_reg[i] <= s_dly_reg[i-1];
            end
            roll_dly_reg[0] <= roll_a;
            yaw_dly_reg[0]  <= yaw_a;
            for (int i = 1; i < RY_DLY; i++)
            begin
                roll_dly_reg[i] <= roll_dly_reg[i-1];
                yaw_dly_reg[i]  <= yaw_dly_reg[i-1];
            end
            inv_dly_reg[0] <= inv_reg;
            for (int i = 1; i < INV_DLY; i++)
            begin
                inv_dly_reg[i] <= inv_dly_reg[i-1];
            end
        end
    end

    // output word; zero quaternion forces zero angles
    assign inv_out         = inv_dly_reg[INV_DLY-1];
    assign euler.valid     = vld_reg[LAT-1];
    assign euler.invalid   = inv_out;
    assign euler.roll_deg  = inv_out ? '0 : roll_dly_reg[RY_DLY-1];
    assign euler.yaw_deg   = inv_out ? '0 : yaw_dly_reg[RY_DLY-1];
    assign euler.pitch_deg = inv_out ? '0 : pitch_a[qte_pkg::PITCH_W-1:0];

endmodule

### bench/tb_quaternion_to_euler.sv
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler: self-checking bench for the quaternion to Euler block
// Drives random and corner quaternions with random idle and stall bursts,
// predicts roll, pitch and yaw with a bit-accurate CORDIC model and compares.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler;

    localparam int LATENCY   = 16 + 69;
    localparam int MAX_CYC   = 400000;
    localparam int N_RANDOM  = 630;
    localparam longint ONE_DEG = 1048576;
    localparam longint NORM_MIN = 64'sd1 << 40;

    typedef struct {
        logic signed [qte_pkg::OUT_W-1:0]   roll;
        logic signed [qte_pkg::PITCH_W-1:0] pitch;
        logic signed [qte_pkg::OUT_W-1:0]   yaw;
        logic                               bad;
    } euler_t;

    // atan(2^-i) in 2^-20 degree
    localparam longint ATAN_STEP [24] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
        938658, 469357, 234682, 117342, 58671, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

    // scoreboard of expected angle words
    class euler_board;
        euler_t pending[$];
        int     mismatches;
        int     checked;

        function void note(euler_t e);
            pending.push_back(e);
        endfunction

        function void check(euler_t got);
            euler_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word roll=%0d pitch=%0d yaw=%0d inv=%0b",
                             got.roll, got.pitch, got.yaw, got.bad);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.roll !== want.roll || got.pitch !== want.pitch ||
                got.yaw !== want.yaw || got.bad !== want.bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch #%0d: exp r=%0d p=%0d y=%0d i=%0b",
                              " got r=%0d p=%0d y=%0d i=%0b"},
                             checked, want.roll, want.pitch, want.yaw, want.bad,
                             got.roll, got.pitch, got.yaw, got.bad);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycle;
    int   stall_len;
    bit   no_idle;
    bit   long_hold;
    bit   hold_done;
    euler_board board;

    qte_quat_if  quat ();
    qte_euler_if euler ();

    quaternion_to_euler u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .quat  (quat.sink),
        .euler (euler.source)
    );

    always #5 clk = ~clk;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // vectoring CORDIC arctangent, 2^-20 degree
    function automatic longint cordic_angle(longint y, longint x);
        longint ang, m, dx, dy;
        ang = 0;
        if (y == 0)
            return x < 0 ? 180 * ONE_DEG : 0;
        if (x == 0)
            return y > 0 ? 90 * ONE_DEG : -90 * ONE_DEG;
        if (x < 0)
        begin
            ang = (y >= 0) ? 180 * ONE_DEG : -180 * ONE_DEG;
            x = -x;
            y = -y;
        end
        m = mag(x) > mag(y) ? mag(x) : mag(y);
        while (m < NORM_MIN)
        begin
            x = x * 2;
            y = y * 2;
            m = m * 2;
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                ang += ATAN_STEP[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                ang -= ATAN_STEP[i];
            end
        end
        return ang;
    endfunction

    // round magnitude half up to 1/128 degree and saturate
    function automatic longint to_deg128(longint ang, longint lim);
        longint r;
        r = (mag(ang) + qte_pkg::RND_HALF) >>> qte_pkg::RND_SHIFT;
        if (r > lim)
            r = lim;
        return ang < 0 ? -r : r;
    endfunction

    function automatic longint int_sqrt(logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    function automatic euler_t predict_euler(qte_pkg::comp_t qw, qte_pkg::comp_t qx,
                                             qte_pkg::comp_t qy, qte_pkg::comp_t qz);
        euler_t e;
        longint w, x, y, z, n2, t, s, c;
        logic [63:0] q;
        w = qw; x = qx; y = qy; z = qz;
        n2 = w * w + x * x + y * y + z * z;
        e.roll = 0; e.pitch = 0; e.yaw = 0; e.bad = 1'b1;
        if (n2 == 0)
            return e;
        e.bad = 1'b0;
        e.roll = qte_pkg::OUT_W'(to_deg128(cordic_angle(2 * (w * x + y * z),
                                 n2 - 2 * (x * x + y * y)), qte_pkg::ROLL_LIM));
        e.yaw = qte_pkg::OUT_W'(to_deg128(cordic_angle(2 * (w * z + x * y),
                                n2 - 2 * (y * y + z * z)), qte_pkg::ROLL_LIM));
        t = 2 * (w * y - z * x);
        q = (64'(mag(t)) << 30) / 64'(n2);
        if (q > (64'd1 << 30))
            q = 64'd1 << 30;
        s = t < 0 ? -longint'(q) : longint'(q);
        c = int_sqrt((64'd1 << 60) - q * q);
        e.pitch = qte_pkg::PITCH_W'(to_deg128(cordic_angle(s, c), qte_pkg::PITCH_LIM));
        return e;
    endfunction

    // offer one quaternion word and wait for acceptance
    task automatic send_quat(qte_pkg::comp_t qw, qte_pkg::comp_t qx,
                             qte_pkg::comp_t qy, qte_pkg::comp_t qz);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            quat.valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
        end
        quat.valid  <= 1'b1;
        quat.quat_w <= qw;
        quat.quat_x <= qx;
        quat.quat_y <= qy;
        quat.quat_z <= qz;
        @(posedge clk);
        while (!quat.ready)
            @(posedge clk);
        board.note(predict_euler(qw, qx, qy, qz));
    endtask

    task automatic wait_drained();
        quat.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic qte_pkg::comp_t rand_comp();
        case ($urandom_range(0, 5))
            0: return qte_pkg::comp_t'($urandom_range(0, 65535));
            1: return qte_pkg::comp_t'($signed($urandom_range(0, 32)) - 16);
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            3: return qte_pkg::comp_t'($signed($urandom_range(0, 200)) - 100);
            default: return qte_pkg::comp_t'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // output sampling and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && euler.valid && euler.ready)
            board.check('{euler.roll_deg, euler.pitch_deg, euler.yaw_deg, euler.invalid});
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            euler.ready <= 1'b0;
            stall_len   <= 0;
            hold_done   <= 1'b0;
        end
        else if (long_hold && !hold_done)
        begin
            euler.ready <= 1'b0;
            stall_len   <= 299;
            hold_done   <= 1'b1;
        end
        else if (stall_len > 0)
        begin
            euler.ready <= 1'b0;
            stall_len <= stall_len - 1;
        end
        else if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            euler.ready <= 1'b0;
            stall_len <= $urandom_range(0, 7);
        end
        else
            euler.ready <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYC)
        begin
            $display("timeout after %0d cycles", cycle);
            $display("tb_quaternion_to_euler: errors");
            $finish;
        end
    end

    initial
    begin
        qte_pkg::comp_t c0, c1, c2, c3;
        rst_n = 0;
        no_idle = 0;
        long_hold = 0;
        board = new();
        quat.valid = 0;
        quat.quat_w = 0;
        quat.quat_x = 0;
        quat.quat_y = 0;
        quat.quat_z = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: zero, identity, axes, extremes, gimbal lock
        send_quat(0, 0, 0, 0);
        send_quat(16384, 0, 0, 0);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_quat(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(11585, 11585, 11585, -11585);
        send_quat(1, 0, 0, 0);
        send_quat(0, 0, 0, -1);
        send_quat(0, 1, 1, 0);
        send_quat(16384, 1, 0, 0);
        send_quat(16384, -1, 0, 0);
        send_quat(0, 16'sh8000, 0, 0);
        send_quat(11585, 0, 0, 11585);
        send_quat(1, 1, 1, 1);
        send_quat(-1, 0, 0, 0);

        // sender pauses until the pipe is empty
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        long_hold <= 1'b1;
        for (int i = 0; i < 150; i++)
            send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());

        for (int i = 0; i < N_RANDOM - 150; i++)
        begin
            if (i == N_RANDOM - 250)
                no_idle = 1;
            c0 = rand_comp(); c1 = rand_comp(); c2 = rand_comp(); c3 = rand_comp();
            if ($urandom_range(0, 15) == 0)
                {c0, c1, c2, c3} = '0;
            send_quat(c0, c1, c2, c3);
        end

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);

        $display("checked %0d Euler words from corner and random quaternions,",
                 board.checked);
        $display("with idle bursts, a long output stall and a full drain pause");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("tb_quaternion_to_euler: clean");
        else
            $display("tb_quaternion_to_euler: errors");
        $finish;
    end

endmodule
